### hw/rtl/bdq_pkg.sv
`default_nettype none

package bdq_pkg;

  localparam int FUNC_W     = 3;
  localparam int WORD_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;
  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_BACK  = 3'd5,
    FN_FIND       = 3'd6,
    FN_REMOVE     = 3'd7
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_READ,
    S_TAKE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic push;
    logic read;
    logic take;
    logic scan;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/bdq_chan_if.sv
`default_nettype none

interface bdq_in_if;
  import bdq_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [WORD_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface bdq_out_if;
  import bdq_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   data_out;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;
  logic [OCC_W-1:0]    removed_count;

  modport source (output valid, output data_out, output found, output status,
                  output occupancy, output removed_count, input ready);
  modport sink (input valid, input data_out, input found, input status,
                input occupancy, input removed_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/bdq_ctl.sv
`default_nettype none

module bdq_ctl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [bdq_pkg::FUNC_W-1:0] in_func,
  output logic                          in_ready,
  input  wire bdq_pkg::dp_sts_t         sts,
  output bdq_pkg::ctl_cmd_t             cmd
);
  import bdq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (func_t'(in_func))
            FN_PUSH_FRONT, FN_PUSH_BACK: state_nxt = S_PUSH;
            FN_POP_FRONT, FN_POP_BACK,
            FN_PEEK_FRONT, FN_PEEK_BACK: state_nxt = S_READ;
            FN_FIND, FN_REMOVE: state_nxt = S_SCAN;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/bdq_dp.sv
`default_nettype none

module bdq_dp #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bdq_pkg::ctl_cmd_t            cmd,
  output bdq_pkg::dp_sts_t                  sts,
  input  wire logic [bdq_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [bdq_pkg::WORD_W-1:0]   in_value,
  input  wire logic                         cfg_we,
  input  wire logic [bdq_pkg::WORD_W-1:0]   cfg_wdata,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [bdq_pkg::WORD_W-1:0]        out_data,
  output logic                              out_found,
  output logic [bdq_pkg::STATUS_W-1:0]      out_status,
  output logic [bdq_pkg::OCC_W-1:0]         out_occupancy,
  output logic [bdq_pkg::OCC_W-1:0]         out_removed
);
  import bdq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  mem_we;
  logic [PW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  rd_en;
  logic [PW-1:0]         rd_addr;

  logic [PW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [WORD_W-1:0]     key_mask_r;
  func_t                 func_r, func_nxt;
  logic [DATA_WIDTH-1:0] value_r, value_nxt;
  logic [CW-1:0]         issue_r, issue_nxt;
  logic [CW-1:0]         kept_r, kept_nxt;
  logic [CW-1:0]         removed_r, removed_nxt;
  logic                  cmp_v_r, cmp_v_nxt;
  logic                  hit_r, hit_nxt;
  logic [DATA_WIDTH-1:0] res_data_r, res_data_nxt;
  logic                  res_found_r, res_found_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  issue_more;
  logic                  is_match;
  logic                  scan_done;

  function automatic logic [PW-1:0] slot_of(logic [PW-1:0] base, logic [CW-1:0] off);
    logic [PW:0] s;
    s = {1'b0, base} + (PW+1)'(off);
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign issue_more = issue_r < count_r;
  assign is_match   = ((rd_data_r ^ value_r) & DATA_WIDTH'(key_mask_r)) == '0;
  assign scan_done  = hit_r || (!issue_more && !cmp_v_r);

  assign sts.scan_done = scan_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    func_nxt       = func_r;
    value_nxt      = value_r;
    issue_nxt      = issue_r;
    kept_nxt       = kept_r;
    removed_nxt    = removed_r;
    cmp_v_nxt      = cmp_v_r;
    hit_nxt        = hit_r;
    res_data_nxt   = res_data_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = value_r;
    rd_en          = 1'b0;
    rd_addr        = '0;

    if (cmd.accept) begin
      func_nxt       = func_t'(in_func);
      value_nxt      = DATA_WIDTH'(in_value);
      issue_nxt      = '0;
      kept_nxt       = '0;
      removed_nxt    = '0;
      cmp_v_nxt      = 1'b0;
      hit_nxt        = 1'b0;
      res_data_nxt   = '0;
      res_found_nxt  = 1'b0;
      res_status_nxt = STS_OK;
    end

    if (cmd.push) begin
      if (count_r == CW'(DEPTH)) begin
        res_status_nxt = STS_FULL;
      end else begin
        mem_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        if (func_r == FN_PUSH_FRONT) begin
          front_nxt = (front_r == '0) ? PW'(DEPTH - 1) : front_r - 1'b1;
          mem_waddr = front_nxt;
        end else begin
          mem_waddr = slot_of(front_r, count_r);
        end
      end
    end

    if (cmd.read) begin
      if (count_r == '0) begin
        res_status_nxt = STS_EMPTY;
      end else begin
        rd_en = 1'b1;
        if (func_r == FN_POP_FRONT || func_r == FN_PEEK_FRONT) begin
          rd_addr = front_r;
        end else begin
          rd_addr = slot_of(front_r, count_r - 1'b1);
        end
      end
    end

    if (cmd.take && count_r != '0) begin
      res_data_nxt  = rd_data_r;
      res_found_nxt = 1'b1;
      if (func_r == FN_POP_FRONT) begin
        front_nxt = slot_of(front_r, CW'(1));
        count_nxt = count_r - 1'b1;
      end else if (func_r == FN_POP_BACK) begin
        count_nxt = count_r - 1'b1;
      end
    end

    // one read issued per cycle, compared in the next cycle; compaction writes
    // land at or behind the read index
    if (cmd.scan) begin
      if (scan_done) begin
        if (func_r == FN_REMOVE) begin
          count_nxt = kept_r;
        end
      end else begin
        cmp_v_nxt = issue_more;
        if (issue_more) begin
          rd_en     = 1'b1;
          rd_addr   = slot_of(front_r, issue_r);
          issue_nxt = issue_r + 1'b1;
        end
        if (cmp_v_r) begin
          if (is_match) begin
            if (func_r == FN_REMOVE) begin
              removed_nxt = removed_r + 1'b1;
            end else begin
              hit_nxt       = 1'b1;
              res_data_nxt  = rd_data_r;
              res_found_nxt = 1'b1;
            end
          end else if (func_r == FN_REMOVE) begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(front_r, kept_r);
            mem_wdata = rd_data_r;
            kept_nxt  = kept_r + 1'b1;
          end
        end
      end
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      key_mask_r  <= '1;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      issue_r     <= '0;
      kept_r      <= '0;
      removed_r   <= '0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
      hit_r       <= hit_nxt;
      issue_r     <= issue_nxt;
      kept_r      <= kept_nxt;
      removed_r   <= removed_nxt;
      if (cfg_we) begin
        key_mask_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    value_r      <= value_nxt;
    res_data_r   <= res_data_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.out_load) begin
      out_data      <= WORD_W'(res_data_r);
      out_found     <= res_found_r;
      out_status    <= res_status_r;
      out_occupancy <= OCC_W'(count_r);
      out_removed   <= OCC_W'(removed_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hw/rtl/bounded_deque_with_search.sv
`default_nettype none
// channel  dir  fields
// in_ch    in   func, value
// out_ch   out  data_out, found, status, occupancy, removed_count
// cfg_*    in   key_mask write (cfg_we, cfg_wdata)
//
// One request in flight. Push writes the RAM in its own state; pop/peek read
// the RAM, then take the word. Find/remove: one entry per cycle through the
// single read port of the entry RAM; find stops at the first match.
// A new request is taken while the last response waits in the output
// register; a stalled response holds the next one in the done state.
// Reset (rst_n low, synchronous) empties the queue and sets key_mask to all ones.

module bounded_deque_with_search #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_W_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  bdq_in_if.sink                          in_ch,
  bdq_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [bdq_pkg::WORD_W-1:0] cfg_wdata
);
  import bdq_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bdq_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_ch.func),
    .in_value      (in_ch.value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_data      (out_ch.data_out),
    .out_found     (out_ch.found),
    .out_status    (out_ch.status),
    .out_occupancy (out_ch.occupancy),
    .out_removed   (out_ch.removed_count)
  );

endmodule

`default_nettype wire

### bench/tb.sv
module tb;
  import bdq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [WORD_W-1:0] data_out;
    logic              found;
    status_t           status;
    logic [OCC_W-1:0]  occupancy;
    logic [OCC_W-1:0]  removed_count;
  } response_t;

  typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_SEARCH} mix_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [WORD_W-1:0] cfg_wdata;

  bdq_in_if  in_if();
  bdq_out_if out_if();

  bounded_deque_with_search u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // deque shadow
  logic [WORD_W-1:0] ring [QDEPTH];
  int                head;
  int                live;
  logic [WORD_W-1:0] match_mask;

  response_t         pending_resp[$];
  response_t         want;
  int                errors = 0;
  int                hold_reqs = 0;
  bit                gaps_on = 1'b1;
  int                burst_left = 0;
  logic [WORD_W-1:0] word_pool [8];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic response_t apply_request(input func_t f, input logic [WORD_W-1:0] v);
    response_t         r;
    int                idx;
    int                kept;
    logic [WORD_W-1:0] w;
    r = '0;
    r.status = STS_OK;
    case (f)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (live >= QDEPTH) begin
          r.status = STS_FULL;
        end else if (f == FN_PUSH_FRONT) begin
          head = (head + QDEPTH - 1) % QDEPTH;
          ring[head] = v;
          live++;
        end else begin
          ring[(head + live) % QDEPTH] = v;
          live++;
        end
      end
      FN_POP_FRONT, FN_POP_BACK, FN_PEEK_FRONT, FN_PEEK_BACK: begin
        if (live == 0) begin
          r.status = STS_EMPTY;
        end else begin
          idx = (f == FN_POP_FRONT || f == FN_PEEK_FRONT) ? head : (head + live - 1) % QDEPTH;
          r.data_out = ring[idx];
          r.found = 1'b1;
          if (f == FN_POP_FRONT) begin
            head = (head + 1) % QDEPTH;
            live--;
          end else if (f == FN_POP_BACK) begin
            live--;
          end
        end
      end
      FN_FIND: begin
        for (int i = 0; i < live && !r.found; i++) begin
          w = ring[(head + i) % QDEPTH];
          if (((w ^ v) & match_mask) == '0) begin
            r.data_out = w;
            r.found = 1'b1;
          end
        end
      end
      default: begin
        kept = 0;
        for (int i = 0; i < live; i++) begin
          w = ring[(head + i) % QDEPTH];
          if (((w ^ v) & match_mask) == '0) begin
            r.removed_count = r.removed_count + 1'b1;
          end else begin
            ring[(head + kept) % QDEPTH] = w;
            kept++;
          end
        end
        live = kept;
      end
    endcase
    r.occupancy = live[OCC_W-1:0];
    return r;
  endfunction

  task automatic send_request(input func_t f, input logic [WORD_W-1:0] v);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= f;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    pending_resp.push_back(apply_request(f, v));
  endtask

  task automatic wait_for_responses();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_resp.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_key_mask(input logic [WORD_W-1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    match_mask = m;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (live > 0 && sel < 60)
      return ring[(head + $urandom_range(0, live - 1)) % QDEPTH] ^ ($urandom & ~match_mask);
    if (sel < 80)
      return word_pool[$urandom_range(0, 7)] ^ ($urandom & ~match_mask);
    return $urandom;
  endfunction

  task automatic send_random(input mix_t mix);
    int                sel;
    int                push_w;
    int                pop_w;
    func_t             f;
    logic [WORD_W-1:0] v;
    case (mix)
      MIX_FILL:   begin push_w = 65; pop_w = 15; end
      MIX_DRAIN:  begin push_w = 25; pop_w = 65; end
      MIX_SEARCH: begin push_w = 45; pop_w = 15; end
      default:    begin push_w = 40; pop_w = 35; end
    endcase
    sel = $urandom_range(0, 99);
    if (sel < push_w) begin
      f = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      v = $urandom_range(0, 1) ? $urandom : word_pool[$urandom_range(0, 7)] ^ ($urandom & ~match_mask);
    end else if (sel < push_w + pop_w) begin
      case ($urandom_range(0, 3))
        0:       f = FN_POP_FRONT;
        1:       f = FN_POP_BACK;
        2:       f = FN_PEEK_FRONT;
        default: f = FN_PEEK_BACK;
      endcase
      v = $urandom;
    end else begin
      f = ($urandom_range(0, 2) != 0) ? FN_FIND : FN_REMOVE;
      v = pick_key();
    end
    send_request(f, v);
  endtask

  task automatic test_empty_queue();
    send_request(FN_POP_FRONT, '0);
    send_request(FN_POP_BACK, '1);
    send_request(FN_PEEK_FRONT, '0);
    send_request(FN_PEEK_BACK, '1);
    send_request(FN_FIND, '1);
    send_request(FN_REMOVE, '0);
  endtask

  task automatic test_both_ends();
    send_request(FN_PUSH_FRONT, '0);
    send_request(FN_PUSH_BACK, '1);
    send_request(FN_PEEK_FRONT, $urandom);
    send_request(FN_PEEK_BACK, $urandom);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < QDEPTH - 2; i++)
      send_request((i % 2) ? FN_PUSH_BACK : FN_PUSH_FRONT, $urandom);
    send_request(FN_PUSH_FRONT, '1);
    send_request(FN_PUSH_BACK, '0);
  endtask

  task automatic test_mask_extremes();
    wait_for_responses();
    set_key_mask('0);
    send_request(FN_FIND, $urandom);
    send_request(FN_REMOVE, $urandom);
    wait_for_responses();
    set_key_mask('1);
  endtask

  task automatic test_hold_off();
    gaps_on = 1'b0;
    hold_reqs++;
    for (int i = 0; i < 40; i++) send_random(MIX_BALANCED);
    wait_for_responses();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    logic [WORD_W-1:0] phase_mask [8];
    mix_t              phase_mix [8];
    phase_mask = '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_FFFF, 32'h0000_0000,
                   32'h0000_00FF, 32'h0000_0001 << $urandom_range(0, 31), $urandom, $urandom};
    phase_mix  = '{MIX_BALANCED, MIX_FILL, MIX_SEARCH, MIX_DRAIN,
                   MIX_FILL, MIX_SEARCH, MIX_BALANCED, MIX_DRAIN};
    for (int p = 0; p < 8; p++) begin
      wait_for_responses();
      set_key_mask(phase_mask[p]);
      foreach (word_pool[k]) word_pool[k] = $urandom;
      repeat (230) send_random(phase_mix[p]);
    end
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_val,
                             input logic [WORD_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_resp.size() == 0) begin
        $display("%0t: unexpected response, expected none, got data_out %h", $time,
                 out_if.data_out);
        errors++;
      end else begin
        want = pending_resp.pop_front();
        check_field("data_out", want.data_out, out_if.data_out);
        check_field("found", WORD_W'(want.found), WORD_W'(out_if.found));
        check_field("status", WORD_W'(want.status), WORD_W'(out_if.status));
        check_field("occupancy", WORD_W'(want.occupancy), WORD_W'(out_if.occupancy));
        check_field("removed_count", WORD_W'(want.removed_count),
                    WORD_W'(out_if.removed_count));
      end
    end
  end

  // receiver: random ready phases, plus a forced hold-off
  initial begin
    int left;
    int ready_pct;
    int hold_left;
    int hold_seen;
    out_if.ready = 1'b0;
    left = 0;
    ready_pct = 100;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = 300;
      end
      if (left == 0) begin
        left = $urandom_range(1, 48);
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 70;
          2:       ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      left--;
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.func  = FN_PUSH_FRONT;
    in_if.value = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    foreach (ring[i]) ring[i] = '0;
    head = 0;
    live = 0;
    match_mask = '1;
    foreach (word_pool[k]) word_pool[k] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_both_ends();
    test_full_queue();
    test_mask_extremes();
    test_hold_off();
    test_random();
    wait_for_responses();
    repeat (QDEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_chan_if.sv
hw/rtl/bdq_ctl.sv
hw/rtl/bdq_dp.sv
hw/rtl/bounded_deque_with_search.sv
bench/tb.sv
